[hdl/utf8c_pkg.sv]
// Package for the UTF-8 cleanup and UTF-16LE transcoder.
// Holds the channel item types, the register indexes and the cleanup table.
// It depends on nothing else.
package utf8c_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned CFG_IDX_BITS   = 2;
  localparam int unsigned CFG_DATA_BITS  = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_WIDE_MODE    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT_ENABLE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_CHARS    = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_last;
  } utf8c_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_end;
  } utf8c_out_t;

  typedef struct packed {
    logic        wide_mode;
    logic        limit_enable;
    logic [15:0] max_chars;
  } utf8c_cfg_t;

  typedef struct packed {
    logic [20:0] point;
    logic [1:0]  need;
  } utf8c_state_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            marker;
    logic            text_end;
  } utf8c_bundle_t;

  typedef struct packed {
    logic            hit;
    logic [1:0]      len;
    logic [2:0][7:0] text;
  } utf8c_subst_t;

  function automatic utf8c_subst_t utf8c_mk(logic [1:0] len, logic [7:0] c0,
                                            logic [7:0] c1, logic [7:0] c2);
    utf8c_subst_t r;
    r.hit     = 1'b1;
    r.len     = len;
    r.text[0] = c0;
    r.text[1] = c1;
    r.text[2] = c2;
    return r;
  endfunction

  function automatic utf8c_subst_t utf8c_subst(logic [20:0] cp);
    utf8c_subst_t r;
    r = '0;
    case (cp)
      21'h02018: r = utf8c_mk(2'd1, 8'h27, 8'h00, 8'h00);
      21'h02019: r = utf8c_mk(2'd1, 8'h27, 8'h00, 8'h00);
      21'h0201C: r = utf8c_mk(2'd1, 8'h22, 8'h00, 8'h00);
      21'h0201D: r = utf8c_mk(2'd2, 8'h27, 8'h27, 8'h00);
      21'h0201E: r = utf8c_mk(2'd2, 8'h2C, 8'h2C, 8'h00);
      21'h0201F: r = utf8c_mk(2'd1, 8'h22, 8'h00, 8'h00);
      21'h02039: r = utf8c_mk(2'd1, 8'h3C, 8'h00, 8'h00);
      21'h0203A: r = utf8c_mk(2'd1, 8'h3E, 8'h00, 8'h00);
      21'h0201A: r = utf8c_mk(2'd1, 8'h2C, 8'h00, 8'h00);
      21'h0201B: r = utf8c_mk(2'd1, 8'h27, 8'h00, 8'h00);
      21'h000A1: r = utf8c_mk(2'd1, 8'h21, 8'h00, 8'h00);
      21'h000BF: r = utf8c_mk(2'd1, 8'h3F, 8'h00, 8'h00);
      21'h0203C: r = utf8c_mk(2'd2, 8'h21, 8'h21, 8'h00);
      21'h02047: r = utf8c_mk(2'd2, 8'h3F, 8'h3F, 8'h00);
      21'h02048: r = utf8c_mk(2'd2, 8'h3F, 8'h21, 8'h00);
      21'h02049: r = utf8c_mk(2'd2, 8'h21, 8'h3F, 8'h00);
      21'h0203D: r = utf8c_mk(2'd2, 8'h3F, 8'h21, 8'h00);
      21'h02020: r = utf8c_mk(2'd1, 8'h2B, 8'h00, 8'h00);
      21'h02021: r = utf8c_mk(2'd2, 8'h2B, 8'h2B, 8'h00);
      21'h02024: r = utf8c_mk(2'd1, 8'h2E, 8'h00, 8'h00);
      21'h02025: r = utf8c_mk(2'd2, 8'h2E, 8'h2E, 8'h00);
      21'h02026: r = utf8c_mk(2'd3, 8'h2E, 8'h2E, 8'h2E);
      21'h02030: r = utf8c_mk(2'd1, 8'h25, 8'h00, 8'h00);
      21'h02031: r = utf8c_mk(2'd2, 8'h25, 8'h25, 8'h00);
      21'h02032: r = utf8c_mk(2'd1, 8'h27, 8'h00, 8'h00);
      21'h02033: r = utf8c_mk(2'd1, 8'h22, 8'h00, 8'h00);
      21'h02034: r = utf8c_mk(2'd1, 8'h22, 8'h00, 8'h00);
      21'h02035: r = utf8c_mk(2'd1, 8'h60, 8'h00, 8'h00);
      21'h02036: r = utf8c_mk(2'd1, 8'h22, 8'h00, 8'h00);
      21'h02037: r = utf8c_mk(2'd1, 8'h22, 8'h00, 8'h00);
      21'h02038: r = utf8c_mk(2'd1, 8'h5E, 8'h00, 8'h00);
      21'h0203B: r = utf8c_mk(2'd1, 8'h2A, 8'h00, 8'h00);
      21'h02042: r = utf8c_mk(2'd3, 8'h2A, 8'h2A, 8'h2A);
      21'h02044: r = utf8c_mk(2'd1, 8'h2F, 8'h00, 8'h00);
      21'h0204E: r = utf8c_mk(2'd1, 8'h2A, 8'h00, 8'h00);
      21'h0204F: r = utf8c_mk(2'd1, 8'h3B, 8'h00, 8'h00);
      21'h02052: r = utf8c_mk(2'd1, 8'h25, 8'h00, 8'h00);
      21'h02053: r = utf8c_mk(2'd1, 8'h7E, 8'h00, 8'h00);
      21'h02055: r = utf8c_mk(2'd1, 8'h2A, 8'h00, 8'h00);
      21'h02013: r = utf8c_mk(2'd1, 8'h2D, 8'h00, 8'h00);
      21'h02014: r = utf8c_mk(2'd1, 8'h2D, 8'h00, 8'h00);
      21'h0200B: r = utf8c_mk(2'd1, 8'h20, 8'h00, 8'h00);
      21'h000A0: r = utf8c_mk(2'd1, 8'h20, 8'h00, 8'h00);
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

[hdl/utf8c_decode.sv]
// Decoder for one input item: sequence tracking, character limit and encoding.
// Pure combinational logic; produces the next state, the next character count and a bundle of results.
// Depends on utf8c_pkg.
module utf8c_decode import utf8c_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  utf8c_in_t               item_i,
  input  utf8c_state_t            state_i,
  input  logic [COUNT_BITS-1:0]   count_i,
  input  utf8c_cfg_t              cfg_i,
  output utf8c_state_t            state_o,
  output logic [COUNT_BITS-1:0]   count_o,
  output utf8c_bundle_t           bundle_o
);

  localparam int unsigned CW = COUNT_BITS;
  localparam int unsigned XW = (CW > 16) ? CW : 16;
  localparam logic [CW+1:0] CMAX = {2'b00, {CW{1'b1}}};

  logic [7:0]          b;
  logic                complete;
  logic [20:0]         cp;
  logic [20:0]         shifted;
  logic [20:0]         v;
  logic [15:0]         hi_unit;
  logic [15:0]         lo_unit;
  utf8c_subst_t        sub;
  logic [3:0][CW-1:0]  cs;
  logic [CW+1:0]       sum;
  logic [3:0]          ok;
  logic [1:0]          taken;
  logic [1:0]          kept;
  logic [2:0]          n;
  logic [3:0][7:0]     bytes;

  assign b       = item_i.in_byte;
  assign shifted = {state_i.point[14:0], b[5:0]};
  assign sub     = utf8c_subst(cp);
  assign v       = cp - 21'h10000;
  assign hi_unit = 16'hD800 + {5'b0, v[20:10]};
  assign lo_unit = 16'hDC00 | {6'b0, v[9:0]};

  always_comb begin
    state_o  = state_i;
    complete = 1'b0;
    cp       = '0;
    if ((state_i.need != 2'd0) && (b[7:6] == 2'b10)) begin
      state_o.point = shifted;
      state_o.need  = state_i.need - 2'd1;
      complete      = (state_i.need == 2'd1);
      cp            = shifted;
    end else begin
      state_o.need = 2'd0;
      if (!b[7]) begin
        complete = 1'b1;
        cp       = {13'b0, b};
      end else if (b[7:5] == 3'b110) begin
        state_o.point = {16'b0, b[4:0]};
        state_o.need  = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        state_o.point = {17'b0, b[3:0]};
        state_o.need  = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        state_o.point = {18'b0, b[2:0]};
        state_o.need  = 2'd3;
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int j = 0; j < 4; j++) begin
      sum   = {2'b00, count_i} + (CW+2)'(j);
      cs[j] = (sum > CMAX) ? {CW{1'b1}} : sum[CW-1:0];
      ok[j] = !cfg_i.limit_enable || (XW'(cs[j]) < XW'(cfg_i.max_chars));
    end
  end

  always_comb begin
    if (!complete) begin
      taken = 2'd0;
    end else if (!cfg_i.wide_mode && sub.hit) begin
      taken = sub.len;
    end else begin
      taken = 2'd1;
    end
    kept = 2'd0;
    for (int j = 0; j < 3; j++) begin
      if ((2'(j) < taken) && ok[j]) begin
        kept = kept + 2'd1;
      end
    end
  end

  always_comb begin
    bytes = '0;
    n     = 3'd0;
    if (complete && ok[0]) begin
      if (cfg_i.wide_mode) begin
        if (cp <= 21'h0FFFF) begin
          bytes[0] = cp[7:0];
          bytes[1] = cp[15:8];
          n        = 3'd2;
        end else begin
          bytes[0] = hi_unit[7:0];
          bytes[1] = hi_unit[15:8];
          bytes[2] = lo_unit[7:0];
          bytes[3] = lo_unit[15:8];
          n        = 3'd4;
        end
      end else if (sub.hit) begin
        bytes[2:0] = sub.text;
        bytes[2]   = (kept == 2'd3) ? sub.text[2] : 8'h00;
        bytes[1]   = (kept >= 2'd2) ? sub.text[1] : 8'h00;
        n          = {1'b0, kept};
      end else if (cp <= 21'h0007F) begin
        bytes[0] = cp[7:0];
        n        = 3'd1;
      end else if (cp <= 21'h007FF) begin
        bytes[0] = {3'b110, cp[10:6]};
        bytes[1] = {2'b10, cp[5:0]};
        n        = 3'd2;
      end else if (cp <= 21'h0FFFF) begin
        bytes[0] = {4'b1110, cp[15:12]};
        bytes[1] = {2'b10, cp[11:6]};
        bytes[2] = {2'b10, cp[5:0]};
        n        = 3'd3;
      end else begin
        bytes[0] = {5'b11110, cp[20:18]};
        bytes[1] = {2'b10, cp[17:12]};
        bytes[2] = {2'b10, cp[11:6]};
        bytes[3] = {2'b10, cp[5:0]};
        n        = 3'd4;
      end
    end
  end

  assign count_o = cs[taken];

  always_comb begin
    bundle_o.bytes    = bytes;
    bundle_o.marker   = (n == 3'd0);
    bundle_o.text_end = item_i.text_last;
    bundle_o.cnt      = ((n == 3'd0) && item_i.text_last) ? 3'd1 : n;
  end

endmodule

[hdl/utf8c_serial.sv]
// Result buffer that holds the bundle of one item and hands it out byte by byte.
// A new bundle loads in the cycle that the last byte of the previous one leaves.
// Depends on utf8c_pkg.
module utf8c_serial import utf8c_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  utf8c_bundle_t bundle_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output utf8c_out_t    out_data_o
);

  logic          vld_q, vld_d;
  logic [1:0]    idx_q, idx_d;
  utf8c_bundle_t bund_q;
  logic          final_byte;
  logic          taken;

  assign final_byte = ({1'b0, idx_q} == (bund_q.cnt - 3'd1));
  assign taken      = vld_q && !out_stall_i;
  assign free_o     = !vld_q || (taken && final_byte);

  assign out_valid_o           = vld_q;
  assign out_data_o.out_byte   = bund_q.bytes[idx_q];
  assign out_data_o.byte_valid = !bund_q.marker;
  assign out_data_o.run_last   = final_byte;
  assign out_data_o.text_end   = bund_q.text_end && final_byte;

  always_comb begin
    vld_d = vld_q;
    idx_d = idx_q;
    if (load_i) begin
      vld_d = 1'b1;
      idx_d = 2'd0;
    end else if (taken && final_byte) begin
      vld_d = 1'b0;
    end else if (taken) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bund_q <= bundle_i;
    end
  end

endmodule

[hdl/utf8_cleanup_utf16_transcoder_unit.sv]
// Top level of the UTF-8 cleanup and UTF-16LE transcoder.
// Instantiates utf8c_decode and utf8c_serial; depends on utf8c_pkg.
//
//   Channel  Direction  Handshake                 Item
//   in       input      in_valid_i / in_stall_o   utf8c_in_t
//   out      output     out_valid_o / out_stall_i utf8c_out_t
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// An item is registered on acceptance, decoded in the next cycle and its one
// to four result bytes leave the result buffer one per cycle while the output is not stalled.
// A byte that gives two results (ASCII in wide mode) gives them low byte first.
// An item that gives no result passes through the input register without waiting for the result buffer.
// Reset clears the sequence state, the character count and the registers.
// A stall on the output holds the buffer and then the input register.
module utf8_cleanup_utf16_transcoder_unit import utf8c_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  utf8c_in_t                in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output utf8c_out_t               out_data_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  utf8c_cfg_t            cfg_q;
  utf8c_state_t          st_q, st_d, st_dec;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_dec;
  logic                  in_vld_q;
  utf8c_in_t             in_q;
  utf8c_bundle_t         bundle;
  logic                  ser_free;
  logic                  adv;
  logic                  load;

  assign adv        = in_vld_q && (ser_free || (bundle.cnt == 3'd0));
  assign load       = adv && (bundle.cnt != 3'd0);
  assign in_stall_o = in_vld_q && !adv;

  utf8c_decode #(
    .COUNT_BITS(COUNT_BITS)
  ) u_decode (
    .item_i  (in_q),
    .state_i (st_q),
    .count_i (cnt_q),
    .cfg_i   (cfg_q),
    .state_o (st_dec),
    .count_o (cnt_dec),
    .bundle_o(bundle)
  );

  utf8c_serial u_serial (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .bundle_i   (bundle),
    .free_o     (ser_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    if (adv) begin
      if (in_q.text_last) begin
        st_d  = '0;
        cnt_d = '0;
      end else begin
        st_d  = st_dec;
        cnt_d = cnt_dec;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= '0;
      cnt_q    <= '0;
      in_vld_q <= 1'b0;
      cfg_q    <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      if (in_valid_i && !in_stall_o) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WIDE_MODE:    cfg_q.wide_mode    <= cfg_data_i[0];
          REG_LIMIT_ENABLE: cfg_q.limit_enable <= cfg_data_i[0];
          REG_MAX_CHARS:    cfg_q.max_chars    <= cfg_data_i[15:0];
          default:          ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  a_marker_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.run_last && out_data_o.text_end)
    else $error("bare end marker without end flags");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_q.text_last |=> (cnt_q == '0) && (st_q.need == 2'd0))
    else $error("state not cleared after the final item");

  a_stall_only_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_valid_o)
    else $error("input stalled while the result buffer is empty");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> ser_free)
    else $error("result buffer overwritten");

endmodule

[sim/utf8c_tb_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard package for the UTF-8 cleanup and UTF-16LE transcoder testbench.
// Holds the cleanup table, a UTF-8 encoder and the class that predicts and checks result items.
// It depends on utf8c_pkg.
package utf8c_tb_pkg;
  import utf8c_pkg::*;

  localparam int unsigned CLEAN_COUNT  = 43;

  typedef struct packed {
    logic [15:0] point;
    logic [1:0]  len;
    logic [23:0] text;
  } clean_entry_t;

  localparam clean_entry_t CLEAN_TABLE [CLEAN_COUNT] = '{
    '{16'h2018, 2'd1, "'  "}, '{16'h2019, 2'd1, "'  "}, '{16'h201C, 2'd1, "\"  "},
    '{16'h201D, 2'd2, "'' "}, '{16'h201E, 2'd2, ",, "}, '{16'h201F, 2'd1, "\"  "},
    '{16'h2039, 2'd1, "<  "}, '{16'h203A, 2'd1, ">  "}, '{16'h201A, 2'd1, ",  "},
    '{16'h201B, 2'd1, "'  "}, '{16'h00A1, 2'd1, "!  "}, '{16'h00BF, 2'd1, "?  "},
    '{16'h203C, 2'd2, "!! "}, '{16'h2047, 2'd2, "?? "}, '{16'h2048, 2'd2, "?! "},
    '{16'h2049, 2'd2, "!? "}, '{16'h203D, 2'd2, "?! "}, '{16'h2020, 2'd1, "+  "},
    '{16'h2021, 2'd2, "++ "}, '{16'h2024, 2'd1, ".  "}, '{16'h2025, 2'd2, ".. "},
    '{16'h2026, 2'd3, "..."}, '{16'h2030, 2'd1, "%  "}, '{16'h2031, 2'd2, "%% "},
    '{16'h2032, 2'd1, "'  "}, '{16'h2033, 2'd1, "\"  "}, '{16'h2034, 2'd1, "\"  "},
    '{16'h2035, 2'd1, "`  "}, '{16'h2036, 2'd1, "\"  "}, '{16'h2037, 2'd1, "\"  "},
    '{16'h2038, 2'd1, "^  "}, '{16'h203B, 2'd1, "*  "}, '{16'h2042, 2'd3, "***"},
    '{16'h2044, 2'd1, "/  "}, '{16'h204E, 2'd1, "*  "}, '{16'h204F, 2'd1, ";  "},
    '{16'h2052, 2'd1, "%  "}, '{16'h2053, 2'd1, "~  "}, '{16'h2055, 2'd1, "*  "},
    '{16'h2013, 2'd1, "-  "}, '{16'h2014, 2'd1, "-  "}, '{16'h200B, 2'd1, "   "},
    '{16'h00A0, 2'd1, "   "}
  };

  function automatic int unsigned utf8_length(logic [20:0] cp);
    if (cp <= 21'h7F) return 1;
    if (cp <= 21'h7FF) return 2;
    if (cp <= 21'hFFFF) return 3;
    return 4;
  endfunction

  // The first byte of the sequence sits in the top bits.
  function automatic logic [31:0] encode_utf8(logic [20:0] cp, int unsigned len);
    case (len)
      1: begin
        return {1'b0, cp[6:0], 24'd0};
      end
      2: begin
        return {3'b110, cp[10:6], 2'b10, cp[5:0], 16'd0};
      end
      3: begin
        return {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'd0};
      end
      default: begin
        return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
      end
    endcase
  endfunction

  class transcode_scoreboard;
    bit                        wide_mode     = 1'b0;
    bit                        limit_enable  = 1'b0;
    logic [15:0]               max_chars     = '0;
    logic [20:0]               partial_point = '0;
    logic [1:0]                bytes_needed  = '0;
    logic [COUNT_BITS_DEF-1:0] chars_emitted = '0;
    utf8c_out_t                expected_bytes[$];
    utf8c_out_t                step_bytes[$];
    int unsigned               errors        = 0;

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
      case (idx)
        REG_WIDE_MODE: begin
          wide_mode = value[0];
        end
        REG_LIMIT_ENABLE: begin
          limit_enable = value[0];
        end
        REG_MAX_CHARS: begin
          max_chars = value[15:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    function bit count_char();
      bit ok;
      ok = !limit_enable || (chars_emitted < max_chars);
      if (chars_emitted != '1) chars_emitted++;
      return ok;
    endfunction

    function void push_byte(logic [7:0] value);
      utf8c_out_t item;
      item            = '0;
      item.out_byte   = value;
      item.byte_valid = 1'b1;
      step_bytes      = {step_bytes, item};
    endfunction

    function void push_unit(logic [15:0] unit);
      push_byte(unit[7:0]);
      push_byte(unit[15:8]);
    endfunction

    function int find_clean(logic [20:0] cp);
      for (int i = 0; i < CLEAN_COUNT; i++) begin
        if (cp == {5'd0, CLEAN_TABLE[i].point}) return i;
      end
      return -1;
    endfunction

    function void emit_code_point(logic [20:0] cp);
      logic [20:0] v;
      logic [31:0] seq;
      int          slot;
      int unsigned n;
      if (wide_mode) begin
        if (!count_char()) return;
        if (cp <= 21'hFFFF) begin
          push_unit(cp[15:0]);
        end else begin
          v = cp - 21'h10000;
          push_unit(16'hD800 + {5'd0, v[20:10]});
          push_unit(16'hDC00 + {6'd0, v[9:0]});
        end
        return;
      end
      slot = find_clean(cp);
      if (slot >= 0) begin
        for (int j = 0; j < CLEAN_TABLE[slot].len; j++) begin
          if (count_char()) push_byte(CLEAN_TABLE[slot].text[23 - 8 * j -: 8]);
        end
        return;
      end
      if (count_char()) begin
        n   = utf8_length(cp);
        seq = encode_utf8(cp, n);
        for (int k = 0; k < n; k++) push_byte(seq[31 - 8 * k -: 8]);
      end
    endfunction

    function void note_text_byte(utf8c_in_t item);
      logic [7:0] b;
      bit         is_lead;
      utf8c_out_t tail;
      b       = item.in_byte;
      is_lead = 1'b1;
      step_bytes.delete();
      if (bytes_needed != 0) begin
        if (b[7:6] == 2'b10) begin
          is_lead       = 1'b0;
          partial_point = {partial_point[14:0], b[5:0]};
          bytes_needed  = bytes_needed - 2'd1;
          if (bytes_needed == 0) emit_code_point(partial_point);
        end else begin
          bytes_needed = '0;
        end
      end
      if (is_lead) begin
        if (!b[7]) begin
          emit_code_point({13'd0, b});
        end else if (b[7:5] == 3'b110) begin
          partial_point = {16'd0, b[4:0]};
          bytes_needed  = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          partial_point = {17'd0, b[3:0]};
          bytes_needed  = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          partial_point = {18'd0, b[2:0]};
          bytes_needed  = 2'd3;
        end
      end
      if (item.text_last) begin
        partial_point = '0;
        bytes_needed  = '0;
        chars_emitted = '0;
        if (step_bytes.size() == 0) step_bytes = {step_bytes, utf8c_out_t'('0)};
        tail          = step_bytes.pop_back();
        tail.text_end = 1'b1;
        step_bytes    = {step_bytes, tail};
      end
      if (step_bytes.size() != 0) begin
        tail          = step_bytes.pop_back();
        tail.run_last = 1'b1;
        step_bytes    = {step_bytes, tail};
      end
      expected_bytes = {expected_bytes, step_bytes};
    endfunction

    function void check_out_byte(utf8c_out_t got);
      utf8c_out_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: expected no result, actual byte %02h valid %b run_last %b text_end %b",
                 $time, got.out_byte, got.byte_valid, got.run_last, got.text_end);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
          got.run_last !== want.run_last || got.text_end !== want.text_end) begin
        errors++;
        $display("%0t: expected %02h/%b/%b/%b, actual %02h/%b/%b/%b",
                 $time, want.out_byte, want.byte_valid, want.run_last, want.text_end,
                 got.out_byte, got.byte_valid, got.run_last, got.text_end);
      end
    endfunction
  endclass

endpackage

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for utf8_cleanup_utf16_transcoder_unit: directed texts, then random UTF-8
// texts under random register settings, with bursty input and stalling output.
// It depends on utf8c_pkg, utf8c_tb_pkg and the block's RTL.
module tb_top;
  import utf8c_pkg::*;
  import utf8c_tb_pkg::*;

  localparam int unsigned HALF_PERIOD   = 5;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned TARGET_ITEMS  = 500;

  typedef enum {RX_FREE, RX_LIGHT, RX_BURSTY} rx_style_e;

  logic                     clk      = 1'b0;
  logic                     rst_n    = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  utf8c_in_t                in_data  = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  utf8c_out_t               out_data;
  logic                     cfg_we   = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  transcode_scoreboard board;
  logic [7:0]          text_bytes[$];
  int unsigned         items_sent   = 0;
  int unsigned         burst_left   = 0;
  int unsigned         quiet_cycles = 0;
  int unsigned         rx_left      = 0;
  int unsigned         rx_hold      = 0;
  rx_style_e           rx_style     = RX_FREE;

  always #HALF_PERIOD clk = ~clk;

  utf8_cleanup_utf16_transcoder_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_style = rx_style_e'($urandom_range(0, 2));
      rx_left  = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_style)
      RX_FREE: begin
        out_stall = 1'b0;
      end
      RX_LIGHT: begin
        out_stall = ($urandom_range(0, 3) == 0);
      end
      default: begin
        if (rx_hold == 0) begin
          rx_hold   = $urandom_range(1, 12);
          out_stall = ~out_stall;
        end
        rx_hold--;
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_out_byte(out_data);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL utf8_cleanup_utf16_transcoder_unit");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    board.write_reg(idx, value);
  endtask

  task automatic write_random_reg(logic [CFG_IDX_BITS-1:0] idx);
    logic [CFG_DATA_BITS-1:0] value;
    case (idx)
      REG_WIDE_MODE: begin
        value = CFG_DATA_BITS'($urandom_range(0, 1));
      end
      REG_LIMIT_ENABLE: begin
        value = CFG_DATA_BITS'($urandom_range(0, 2) != 0);
      end
      default: begin
        case ($urandom_range(0, 4))
          0: value = '0;
          1: value = '1;
          4: value = CFG_DATA_BITS'($urandom_range(0, 16'hFFFF));
          default: value = CFG_DATA_BITS'($urandom_range(1, 12));
        endcase
      end
    endcase
    write_reg(idx, value);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] value, bit last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_data.in_byte   = value;
    in_data.text_last = last;
    in_valid          = 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_text_byte(in_data);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(bit allow_hold);
    foreach (text_bytes[k]) begin
      if (allow_hold && k != 0 && $urandom_range(0, 19) == 0) begin
        drain_results();
        write_random_reg(CFG_IDX_BITS'($urandom_range(REG_WIDE_MODE, REG_MAX_CHARS)));
      end
      send_byte(text_bytes[k], k == text_bytes.size() - 1);
    end
  endtask

  function automatic void add_element();
    logic [31:0] seq;
    logic [20:0] cp;
    int unsigned len;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind >= 92) begin
      text_bytes = {text_bytes, 8'($urandom_range(0, 255))};
      return;
    end
    if (kind >= 78 && kind < 84) begin
      if ($urandom_range(0, 1) != 0) text_bytes = {text_bytes, 8'($urandom_range(8'h80, 8'hBF))};
      else text_bytes = {text_bytes, 8'($urandom_range(8'hF8, 8'hFF))};
      return;
    end
    if (kind < 25) begin
      cp = 21'($urandom_range(0, 21'h7F));
    end else if (kind < 42) begin
      cp = {5'd0, CLEAN_TABLE[$urandom_range(0, CLEAN_COUNT - 1)].point};
    end else if (kind < 52) begin
      cp = 21'($urandom_range(21'h80, 21'h7FF));
    end else if (kind < 62) begin
      cp = 21'($urandom_range(21'h800, 21'hFFFF));
    end else if (kind < 72) begin
      cp = 21'($urandom_range(21'h10000, 21'h1FFFFF));
    end else begin
      cp = 21'($urandom_range(0, 21'h1FFFFF));
    end
    len = utf8_length(cp);
    if (kind >= 72 && kind < 78) begin
      len = $urandom_range(2, 4);
      cp  = 21'($urandom_range(0, (len == 2) ? 21'h7F : (len == 3) ? 21'h7FF : 21'hFFFF));
    end else if (kind >= 84) begin
      len = $urandom_range(2, 4);
      seq = encode_utf8(cp, len);
      len = $urandom_range(1, len - 1);
      for (int k = 0; k < len; k++) text_bytes = {text_bytes, seq[31 - 8 * k -: 8]};
      return;
    end
    seq = encode_utf8(cp, len);
    for (int k = 0; k < len; k++) text_bytes = {text_bytes, seq[31 - 8 * k -: 8]};
  endfunction

  initial begin
    board = new;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_reg(REG_WIDE_MODE, '0);
    write_reg(REG_LIMIT_ENABLE, '0);
    write_reg(REG_MAX_CHARS, '1);
    text_bytes = '{8'h00, 8'h7F, 8'hC2, 8'hA0, 8'hDF, 8'hBF, 8'hE2, 8'h80, 8'hA6,
                   8'hE2, 8'h80, 8'h9D, 8'hE2, 8'h80, 8'h8B, 8'hFF, 8'h80};
    send_text(1'b0);
    text_bytes = '{8'hE2, 8'h80, 8'h41};
    send_text(1'b0);
    drain_results();
    write_reg(REG_WIDE_MODE, CFG_DATA_BITS'(1));
    write_reg(REG_LIMIT_ENABLE, CFG_DATA_BITS'(1));
    write_reg(REG_MAX_CHARS, CFG_DATA_BITS'(1));
    text_bytes = '{8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h41, 8'hC3};
    send_text(1'b0);

    while (items_sent < TARGET_ITEMS) begin
      drain_results();
      write_random_reg(REG_WIDE_MODE);
      write_random_reg(REG_LIMIT_ENABLE);
      write_random_reg(REG_MAX_CHARS);
      repeat ($urandom_range(1, 4)) begin
        text_bytes.delete();
        repeat ($urandom_range(1, 12)) add_element();
        send_text(1'b1);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (board.errors == 0) begin
      $display("PASS utf8_cleanup_utf16_transcoder_unit");
    end else begin
      $display("FAIL utf8_cleanup_utf16_transcoder_unit");
    end
    $finish;
  end

endmodule
